>>> hdl/pce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_pkg: shared types and constants of the pixel color enhancer
// Pixel payload structs, register indexes and reset values, the restoring
// division step, and the gamma 1.06 table built at elaboration.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int GAMMA_TABLE_BITS = 10;
	localparam int GAMMA_N          = 1 << GAMMA_TABLE_BITS;

	// quotients of x/y with x <= y reach 1.0, so 17 bits
	localparam int DIV_STEPS = 17;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CON_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HL_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HL_STR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_V_SCALE  = 3'd4;

	localparam logic [15:0] RST_SAT_GAIN = 16'd22118;
	localparam logic [15:0] RST_CON_GAIN = 16'd18350;
	localparam logic [7:0]  RST_HL_THR   = 8'd200;
	localparam logic [15:0] RST_HL_STR   = 16'd49152;
	localparam logic [15:0] RST_V_SCALE  = 16'd64225;

	localparam logic [15:0] LUMA_R = 16'd13933;
	localparam logic [15:0] LUMA_G = 16'd46871;
	localparam logic [15:0] LUMA_B = 16'd4732;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	typedef struct packed {
		logic        qbit;
		logic [15:0] rem;
	} div_step_t;

	// one restoring step: trial is the shifted partial remainder
	function automatic div_step_t div_step(input logic [16:0] trial, input logic [15:0] den);
		div_step_t r;
		if (trial >= {1'b0, den}) begin
			r.qbit = 1'b1;
			r.rem  = 16'(trial - {1'b0, den});
		end else begin
			r.qbit = 1'b0;
			r.rem  = trial[15:0];
		end
		return r;
	endfunction

	localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
	localparam logic [63:0] LN2_Q30   = 64'd744261118;
	localparam logic [63:0] GAMMA_Q24 = 64'd17783849;

	typedef logic [15:0] gamma_tab_t [GAMMA_N+1];

	// 2^(-x), x in Q24 below one, result in Q30 (series of exp)
	function automatic logic [63:0] exp2_neg_frac(input logic [63:0] x);
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] sum;
		z    = (x * LN2_Q30) >> 24;
		term = Q30_ONE;
		sum  = Q30_ONE;
		for (int n = 1; n <= 20; n++) begin
			term = ((term * z) >> 30) / 64'(n);
			if ((n % 2) == 1) sum = sum - term;
			else sum = sum + term;
		end
		return sum;
	endfunction

	// entry k holds 65535*(k/N)^1.06 through integer log2 and exp2
	function automatic gamma_tab_t gamma_build();
		gamma_tab_t  tab;
		logic [63:0] kk;
		logic [63:0] mant;
		logic [63:0] frac;
		logic [63:0] mag;
		logic [63:0] scaled;
		logic [63:0] ip;
		logic [63:0] val;
		int          e;
		tab[0] = 16'd0;
		for (int k = 1; k <= GAMMA_N; k++) begin
			kk = 64'(k);
			e  = 0;
			for (int i = 0; i < GAMMA_TABLE_BITS; i++)
				if ((kk << e) < 64'(GAMMA_N)) e++;
			mant = ((kk << e) << 30) >> GAMMA_TABLE_BITS;
			frac = 64'd0;
			for (int j = 0; j < 24; j++) begin
				mant = (mant * mant) >> 30;
				if (mant >= (Q30_ONE << 1)) begin
					mant = mant >> 1;
					frac = frac | (64'd1 << (23 - j));
				end
			end
			mag    = 64'(e) << 24;
			mag    = (frac > mag) ? 64'd0 : mag - frac;
			scaled = (mag * GAMMA_Q24 + (64'd1 << 23)) >> 24;
			ip     = scaled >> 24;
			val    = (ip >= 64'd31) ? 64'd0 : (exp2_neg_frac(scaled & 64'hFFFFFF) >> ip);
			val    = (val * 64'd65535 + (64'd1 << 29)) >> 30;
			tab[k] = (val > 64'd65535) ? 16'hFFFF : val[15:0];
		end
		return tab;
	endfunction

	localparam gamma_tab_t GAMMA_TAB = gamma_build();

endpackage
`default_nettype wire

>>> hdl/pixel_color_enhancer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_enhancer: highlight compression, HSV saturation and contrast,
// and gamma on one RGB pixel per beat
// A single stall-controlled pipeline of 52 register stages.
// ----------------------------------------------------------------------------
// Accepts one pixel every clock while src_stall is low and delivers each result
// in order. The depth is set by two 17-stage restoring dividers
// (one for the highlight excess, one pair for saturation and hue, one
// quotient bit per stage) plus the multiply stages around them and a
// registered gamma table read. The whole pipe freezes while the output beat
// is held by dst_stall, so src_stall follows dst_valid and dst_stall.
// Configuration writes take effect on pixels in flight and should be made
// with the pipe empty.
module pixel_color_enhancer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pce_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [15:0]                    wr_data,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  pce_pkg::pix_in_t               src_data,
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output pce_pkg::pix_out_t              dst_data
);

	localparam int TB = pce_pkg::GAMMA_TABLE_BITS;
	localparam int DS = pce_pkg::DIV_STEPS;

	logic adv;

	logic [15:0] sat_gain_q, con_gain_q, hl_str_q, v_scale_q;
	logic [7:0]  hl_thr_q;

	assign src_stall = dst_valid & dst_stall;
	assign adv       = ~src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_gain_q <= pce_pkg::RST_SAT_GAIN;
			con_gain_q <= pce_pkg::RST_CON_GAIN;
			hl_thr_q   <= pce_pkg::RST_HL_THR;
			hl_str_q   <= pce_pkg::RST_HL_STR;
			v_scale_q  <= pce_pkg::RST_V_SCALE;
		end else if (wr_en) begin
			case (wr_index)
				pce_pkg::CFG_SAT_GAIN: sat_gain_q <= wr_data;
				pce_pkg::CFG_CON_GAIN: con_gain_q <= wr_data;
				pce_pkg::CFG_HL_THR:   hl_thr_q   <= wr_data[7:0];
				pce_pkg::CFG_HL_STR:   hl_str_q   <= wr_data;
				pce_pkg::CFG_V_SCALE:  v_scale_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- luma ----------------
	logic [2:0][15:0] ch_in;
	assign ch_in[0] = {src_data.red_in, src_data.red_in};
	assign ch_in[1] = {src_data.green_in, src_data.green_in};
	assign ch_in[2] = {src_data.blue_in, src_data.blue_in};

	logic             vld_s1;
	logic [2:0][15:0] ch_s1;
	logic [31:0]      pr_s1, pg_s1, pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= src_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1 <= ch_in;
			pr_s1 <= 32'(ch_in[0]) * 32'(pce_pkg::LUMA_R);
			pg_s1 <= 32'(ch_in[1]) * 32'(pce_pkg::LUMA_G);
			pb_s1 <= 32'(ch_in[2]) * 32'(pce_pkg::LUMA_B);
		end
	end

	logic [33:0] luma_sum;
	logic [15:0] luma, thr;
	assign luma_sum = 34'(pr_s1) + 34'(pg_s1) + 34'(pb_s1) + 34'd32768;
	assign luma     = luma_sum[31:16];
	assign thr      = {hl_thr_q, hl_thr_q};

	// ---------------- highlight excess divider ----------------
	// entry 0 is loaded from the luma stage, entry k+1 holds quotient bit k
	logic [DS:0]      exc_vld_s;
	logic [15:0]      exc_rem_s [DS+1];
	logic [15:0]      exc_den_s [DS+1];
	logic [16:0]      exc_quo_s [DS+1];
	logic [2:0][15:0] exc_ch_s  [DS+1];
	logic [DS:0]      exc_hi_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exc_vld_s[0] <= 1'b0;
		else if (adv) exc_vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			exc_rem_s[0] <= luma - thr;
			exc_den_s[0] <= ~thr;
			exc_quo_s[0] <= '0;
			exc_ch_s[0]  <= ch_s1;
			exc_hi_s[0]  <= luma > thr;
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_exc
		logic [16:0]         trial;
		pce_pkg::div_step_t  st;
		assign trial = (k == 0) ? {1'b0, exc_rem_s[k]} : {exc_rem_s[k], 1'b0};
		assign st    = pce_pkg::div_step(trial, exc_den_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) exc_vld_s[k+1] <= 1'b0;
			else if (adv) exc_vld_s[k+1] <= exc_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				exc_rem_s[k+1] <= st.rem;
				exc_den_s[k+1] <= exc_den_s[k];
				exc_quo_s[k+1] <= {exc_quo_s[k][15:0], st.qbit};
				exc_ch_s[k+1]  <= exc_ch_s[k];
				exc_hi_s[k+1]  <= exc_hi_s[k];
			end
		end
	end

	// ---------------- compression factor ----------------
	logic             vld_s3, vld_s4, vld_s5, vld_s6;
	logic [32:0]      red_s3;
	logic             hi_s3;
	logic [2:0][15:0] ch_s3, ch_s4, ch_s6;
	logic [16:0]      factor_s4;
	logic [2:0][32:0] cp_s5;

	logic [33:0] red_sum;
	logic [16:0] red_r, factor;
	assign red_sum = 34'(red_s3) + 34'd32768;
	assign red_r   = red_sum[32:16];

	always_comb begin
		factor = (red_r[16]) ? 17'd0 : 17'h10000 - red_r;
		if (factor < 17'd16384) factor = 17'd16384;
		if (!hi_s3) factor = 17'h10000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= exc_vld_s[DS];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s3    <= 33'(exc_quo_s[DS]) * 33'(hl_str_q);
			hi_s3     <= exc_hi_s[DS];
			ch_s3     <= exc_ch_s[DS];
			factor_s4 <= factor;
			ch_s4     <= ch_s3;
			for (int i = 0; i < 3; i++) begin
				cp_s5[i] <= 33'(ch_s4[i]) * 33'(factor_s4);
				ch_s6[i] <= 16'((34'(cp_s5[i]) + 34'd32768) >> 16);
			end
		end
	end

	// ---------------- max, min and hue branch ----------------
	logic        mx_is_r, mx_is_g, h_neg;
	logic [15:0] mx, mn, dlt, h_diff;
	logic [2:0]  h_base;

	always_comb begin
		mx_is_r = (ch_s6[0] >= ch_s6[1]) && (ch_s6[0] >= ch_s6[2]);
		mx_is_g = !mx_is_r && (ch_s6[1] >= ch_s6[2]);
		mn = ch_s6[0];
		if (ch_s6[1] < mn) mn = ch_s6[1];
		if (ch_s6[2] < mn) mn = ch_s6[2];
		if (mx_is_r) begin
			mx     = ch_s6[0];
			h_base = 3'd0;
			h_neg  = ch_s6[1] < ch_s6[2];
			h_diff = h_neg ? ch_s6[2] - ch_s6[1] : ch_s6[1] - ch_s6[2];
		end else if (mx_is_g) begin
			mx     = ch_s6[1];
			h_base = 3'd2;
			h_neg  = ch_s6[2] < ch_s6[0];
			h_diff = h_neg ? ch_s6[0] - ch_s6[2] : ch_s6[2] - ch_s6[0];
		end else begin
			mx     = ch_s6[2];
			h_base = 3'd4;
			h_neg  = ch_s6[0] < ch_s6[1];
			h_diff = h_neg ? ch_s6[1] - ch_s6[0] : ch_s6[0] - ch_s6[1];
		end
		dlt = mx - mn;
	end

	// ---------------- saturation and hue dividers ----------------
	logic [DS:0]  hsv_vld_s;
	logic [15:0]  sat_rem_s [DS+1];
	logic [16:0]  sat_quo_s [DS+1];
	logic [15:0]  hue_rem_s [DS+1];
	logic [16:0]  hue_quo_s [DS+1];
	logic [15:0]  hsv_mx_s  [DS+1];
	logic [15:0]  hsv_d_s   [DS+1];
	logic [2:0]   hsv_base_s[DS+1];
	logic [DS:0]  hsv_neg_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hsv_vld_s[0] <= 1'b0;
		else if (adv) hsv_vld_s[0] <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_rem_s[0]  <= dlt;
			sat_quo_s[0]  <= '0;
			hue_rem_s[0]  <= h_diff;
			hue_quo_s[0]  <= '0;
			hsv_mx_s[0]   <= mx;
			hsv_d_s[0]    <= dlt;
			hsv_base_s[0] <= h_base;
			hsv_neg_s[0]  <= h_neg;
		end
	end

	for (genvar k = 0; k < DS; k++) begin : g_hsv
		logic [16:0]         s_trial, h_trial;
		pce_pkg::div_step_t  s_st, h_st;
		assign s_trial = (k == 0) ? {1'b0, sat_rem_s[k]} : {sat_rem_s[k], 1'b0};
		assign h_trial = (k == 0) ? {1'b0, hue_rem_s[k]} : {hue_rem_s[k], 1'b0};
		assign s_st    = pce_pkg::div_step(s_trial, hsv_mx_s[k]);
		assign h_st    = pce_pkg::div_step(h_trial, hsv_d_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) hsv_vld_s[k+1] <= 1'b0;
			else if (adv) hsv_vld_s[k+1] <= hsv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sat_rem_s[k+1]  <= s_st.rem;
				sat_quo_s[k+1]  <= {sat_quo_s[k][15:0], s_st.qbit};
				hue_rem_s[k+1]  <= h_st.rem;
				hue_quo_s[k+1]  <= {hue_quo_s[k][15:0], h_st.qbit};
				hsv_mx_s[k+1]   <= hsv_mx_s[k];
				hsv_d_s[k+1]    <= hsv_d_s[k];
				hsv_base_s[k+1] <= hsv_base_s[k];
				hsv_neg_s[k+1]  <= hsv_neg_s[k];
			end
		end
	end

	// ---------------- gains ----------------
	logic [16:0] s_raw, h_q;
	logic [18:0] h6;
	logic [2:0]  h_top;
	logic        c_pos;
	logic [15:0] c_abs;

	always_comb begin
		s_raw = (hsv_mx_s[DS] == 16'd0) ? 17'd0 : sat_quo_s[DS];
		h_q   = (hsv_d_s[DS] == 16'd0) ? 17'd0 : hue_quo_s[DS];
		// wrap a negative red-sector hue to the top of the circle
		h_top = (hsv_neg_s[DS] && hsv_base_s[DS] == 3'd0) ? 3'd6 : hsv_base_s[DS];
		if (hsv_neg_s[DS]) h6 = {h_top, 16'd0} - 19'(h_q);
		else h6 = {h_top, 16'd0} + 19'(h_q);
		c_pos = hsv_mx_s[DS] >= 16'd32768;
		c_abs = c_pos ? hsv_mx_s[DS] - 16'd32768 : 16'd32768 - hsv_mx_s[DS];
	end

	logic        vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic [32:0] sg_s8;
	logic [31:0] cprod_s8;
	logic        cpos_s8;
	logic [18:0] h6_s8;

	logic [33:0] sg_sum;
	logic [19:0] sg_r;
	logic [32:0] cp_sum;
	logic [18:0] cp_r;
	logic [16:0] s_gain;
	logic [17:0] vc;
	logic [2:0]  sec;

	assign sg_sum = 34'(sg_s8) + 34'd8192;
	assign sg_r   = sg_sum[33:14];
	assign s_gain = (sg_r > 20'h10000) ? 17'h10000 : sg_r[16:0];
	assign cp_sum = 33'(cprod_s8) + 33'd8192;
	assign cp_r   = cp_sum[32:14];

	always_comb begin
		if (cpos_s8) vc = 18'(19'd32768 + cp_r);
		else if (cp_r > 19'd32768) vc = 18'd0;
		else vc = 18'(19'd32768 - cp_r);
		sec = (h6_s8[18:16] >= 3'd6) ? h6_s8[18:16] - 3'd6 : h6_s8[18:16];
	end

	logic [16:0] s_s9;
	logic [17:0] vc_s9;
	logic [2:0]  sec_s9, sec_s10, sec_s11, sec_s12;
	logic [15:0] f_s9;

	logic [33:0] vs_s10;
	logic [32:0] sf_s10;
	logic [33:0] st_s10;
	logic [16:0] s_s10;

	logic [34:0] vs_sum;
	logic [18:0] vs_r;
	logic [33:0] sf_sum;
	logic [34:0] st_sum;
	logic [16:0] sf_r, st_r;

	assign vs_sum = 35'(vs_s10) + 35'd32768;
	assign vs_r   = vs_sum[34:16];
	assign sf_sum = 34'(sf_s10) + 34'd32768;
	assign sf_r   = sf_sum[32:16];
	assign st_sum = 35'(st_s10) + 35'd32768;
	assign st_r   = st_sum[32:16];

	logic [15:0] v_s11, v_s12;
	logic [16:0] omp_s11, omq_s11, omt_s11;
	logic        sz_s11, sz_s12;
	logic [32:0] mp_s12, mq_s12, mt_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (adv) begin
			vld_s8  <= hsv_vld_s[DS];
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sg_s8    <= 33'(s_raw) * 33'(sat_gain_q);
			cprod_s8 <= 32'(c_abs) * 32'(con_gain_q);
			cpos_s8  <= c_pos;
			h6_s8    <= h6;

			s_s9   <= s_gain;
			vc_s9  <= vc;
			sec_s9 <= sec;
			f_s9   <= h6_s8[15:0];

			vs_s10  <= 34'(vc_s9) * 34'(v_scale_q);
			sf_s10  <= 33'(s_s9) * 33'(f_s9);
			st_s10  <= 34'(s_s9) * 34'(17'h10000 - {1'b0, f_s9});
			s_s10   <= s_s9;
			sec_s10 <= sec_s9;

			v_s11   <= (vs_r > 19'd65535) ? 16'hFFFF : vs_r[15:0];
			omp_s11 <= 17'h10000 - s_s10;
			omq_s11 <= 17'h10000 - sf_r;
			omt_s11 <= 17'h10000 - st_r;
			sz_s11  <= s_s10 == 17'd0;
			sec_s11 <= sec_s10;

			mp_s12  <= 33'(v_s11) * 33'(omp_s11);
			mq_s12  <= 33'(v_s11) * 33'(omq_s11);
			mt_s12  <= 33'(v_s11) * 33'(omt_s11);
			v_s12   <= v_s11;
			sz_s12  <= sz_s11;
			sec_s12 <= sec_s11;
		end
	end

	// ---------------- back to RGB ----------------
	logic [15:0]      pv, qv, tv;
	logic [2:0][15:0] rgb;

	assign pv = 16'((34'(mp_s12) + 34'd32768) >> 16);
	assign qv = 16'((34'(mq_s12) + 34'd32768) >> 16);
	assign tv = 16'((34'(mt_s12) + 34'd32768) >> 16);

	always_comb begin
		if (sz_s12) begin
			rgb = {v_s12, v_s12, v_s12};
		end else begin
			case (sec_s12)
				3'd0:    begin rgb[0] = v_s12; rgb[1] = tv;    rgb[2] = pv;    end
				3'd1:    begin rgb[0] = qv;    rgb[1] = v_s12; rgb[2] = pv;    end
				3'd2:    begin rgb[0] = pv;    rgb[1] = v_s12; rgb[2] = tv;    end
				3'd3:    begin rgb[0] = pv;    rgb[1] = qv;    rgb[2] = v_s12; end
				3'd4:    begin rgb[0] = tv;    rgb[1] = pv;    rgb[2] = v_s12; end
				default: begin rgb[0] = v_s12; rgb[1] = pv;    rgb[2] = qv;    end
			endcase
		end
	end

	logic [2:0][15:0] o_s13;

	always_ff @(posedge clk) begin
		if (adv) o_s13 <= rgb;
	end

	// ---------------- gamma and 8-bit rounding ----------------
	logic             vld_s14, vld_s15, vld_s16, vld_s17;
	logic [2:0][15:0] ga_s14, gb_s14, fr_s14;
	logic [2:0][15:0] ga_s15;
	logic [2:0][31:0] ip_s15;
	logic [2:0]       up_s15;
	logic [2:0][16:0] x_s16, x_s17;
	logic [2:0][8:0]  q0_s17;

	logic [2:0][TB:0]  gidx;
	logic [2:0][15:0]  gfr;
	logic [2:0][15:0]  gdif;
	logic [2:0][15:0]  grnd;
	logic [2:0][15:0]  gy;
	logic [2:0][24:0]  x255;
	logic [2:0][17:0]  rmd;
	logic [2:0][8:0]   qfix;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gidx[i] = {1'b0, o_s13[i][15 -: TB]};
			gfr[i]  = {o_s13[i][15-TB:0], TB'(0)};
			gdif[i] = (gb_s14[i] >= ga_s14[i]) ? gb_s14[i] - ga_s14[i]
			                                   : ga_s14[i] - gb_s14[i];
			grnd[i] = 16'((33'(ip_s15[i]) + 33'd32768) >> 16);
			gy[i]   = up_s15[i] ? ga_s15[i] + grnd[i] : ga_s15[i] - grnd[i];
			x255[i] = (25'(x_s16[i]) << 8) - 25'(x_s16[i]);
			// estimate can be one short of x/257: fix with one compare
			rmd[i]  = 18'(x_s17[i]) - 18'({q0_s17[i], 8'd0}) - 18'(q0_s17[i]);
			qfix[i] = (rmd[i] >= 18'd257) ? q0_s17[i] + 9'd1 : q0_s17[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14   <= 1'b0;
			vld_s15   <= 1'b0;
			vld_s16   <= 1'b0;
			vld_s17   <= 1'b0;
			dst_valid <= 1'b0;
		end else if (adv) begin
			vld_s14   <= vld_s13;
			vld_s15   <= vld_s14;
			vld_s16   <= vld_s15;
			vld_s17   <= vld_s16;
			dst_valid <= vld_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ga_s14[i] <= pce_pkg::GAMMA_TAB[gidx[i]];
				gb_s14[i] <= pce_pkg::GAMMA_TAB[gidx[i] + (TB+1)'(1)];
				fr_s14[i] <= gfr[i];

				ga_s15[i] <= ga_s14[i];
				up_s15[i] <= gb_s14[i] >= ga_s14[i];
				ip_s15[i] <= 32'(gdif[i]) * 32'(fr_s14[i]);

				x_s16[i]  <= {1'b0, gy[i]} + 17'd128;

				x_s17[i]  <= x_s16[i];
				q0_s17[i] <= x255[i][24:16];
			end
			dst_data.red_out   <= qfix[0][7:0];
			dst_data.green_out <= qfix[1][7:0];
			dst_data.blue_out  <= qfix[2][7:0];
		end
	end

endmodule
`default_nettype wire
